// File: rtl/clock_trial_episode_controller_assert.svh
// assertion macros for the clock trial episode controller
`ifndef CLOCK_TRIAL_EPISODE_CONTROLLER_ASSERT_SVH
`define CLOCK_TRIAL_EPISODE_CONTROLLER_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define CTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define CTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cte_pkg.sv
// shared types, widths and codes of the clock trial episode controller
package cte_pkg;

    // field widths
    localparam int CLOCK_BITS    = 16;
    localparam int TICK_BITS     = 16;
    localparam int TEMP_BITS     = 8;
    localparam int UTIL_BITS     = 7;
    localparam int ECC_BITS      = 16;
    localparam int EPISODE_BITS  = 32;
    localparam int SUM_BITS      = TICK_BITS + 8;
    localparam int CNT_BITS      = TICK_BITS + 1;
    localparam int DIV_STEP_BITS = $clog2(SUM_BITS);

    // apb port
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // register reset values
    localparam logic [TEMP_BITS-1:0]  TEMP_LIMIT_RESET     = TEMP_BITS'(90);
    localparam logic [UTIL_BITS-1:0]  UTIL_THRESHOLD_RESET = UTIL_BITS'(50);
    localparam logic [CLOCK_BITS-1:0] BASELINE_RESET       = CLOCK_BITS'(1000);

    // episode phases
    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PROPOSE  = 3'd1,
        PH_VALIDATE = 3'd2,
        PH_APPLY    = 3'd3,
        PH_MONITOR  = 3'd4,
        PH_DECIDE   = 3'd5,
        PH_ROLLBACK = 3'd6
    } phase_t;

    // propose status codes
    typedef enum logic [1:0] {
        PS_NONE     = 2'd0,
        PS_ACCEPTED = 2'd1,
        PS_BUSY     = 2'd2
    } status_t;

    // outcome codes
    typedef enum logic [2:0] {
        OC_NONE          = 3'd0,
        OC_PROMOTED      = 3'd1,
        OC_REJECTED      = 3'd2,
        OC_GUARDRAIL     = 3'd3,
        OC_ROLLBACK_DONE = 3'd4
    } outcome_t;

    // register indexes
    typedef enum logic [1:0] {
        REG_TEMP_LIMIT     = 2'd0,
        REG_UTIL_THRESHOLD = 2'd1,
        REG_BASELINE_CLOCK = 2'd2
    } reg_idx_t;

    // controller states
    typedef enum logic [3:0] {
        CS_IDLE  = 4'b0001,
        CS_STEP  = 4'b0010,
        CS_DIV   = 4'b0100,
        CS_WRITE = 4'b1000
    } ctl_state_t;

    // configuration registers
    typedef struct packed {
        logic [TEMP_BITS-1:0]  temp_limit;
        logic [UTIL_BITS-1:0]  util_threshold;
        logic [CLOCK_BITS-1:0] baseline_clock;
    } cte_cfg_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic commit;
    } cte_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic decide_step;
        logic div_done;
    } cte_sts_t;

endpackage

// File: rtl/cte_regs.sv
// apb configuration registers
module cte_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cte_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cte_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cte_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    output cte_pkg::cte_cfg_t                  cfg
);
    import cte_pkg::*;

    cte_cfg_t cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temp_limit     <= TEMP_LIMIT_RESET;
            cfg_reg.util_threshold <= UTIL_THRESHOLD_RESET;
            cfg_reg.baseline_clock <= BASELINE_RESET;
        end else if (wr_en) begin
            case (idx)
                REG_TEMP_LIMIT:     cfg_reg.temp_limit     <= pwdata[TEMP_BITS-1:0];
                REG_UTIL_THRESHOLD: cfg_reg.util_threshold <= pwdata[UTIL_BITS-1:0];
                REG_BASELINE_CLOCK: cfg_reg.baseline_clock <= pwdata[CLOCK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (idx)
            REG_TEMP_LIMIT:     prdata = APB_DATA_BITS'(cfg_reg.temp_limit);
            REG_UTIL_THRESHOLD: prdata = APB_DATA_BITS'(cfg_reg.util_threshold);
            REG_BASELINE_CLOCK: prdata = APB_DATA_BITS'(cfg_reg.baseline_clock);
            default:            prdata = '0;
        endcase
    end

endmodule

// File: rtl/cte_div.sv
// bit-serial restoring divider for the average utilization
module cte_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [cte_pkg::SUM_BITS-1:0]  dividend,
    input  logic [cte_pkg::CNT_BITS-1:0]  divisor,
    output logic [cte_pkg::SUM_BITS-1:0]  quotient,
    output logic                          done
);
    import cte_pkg::*;

    localparam logic [DIV_STEP_BITS-1:0] LAST_STEP = DIV_STEP_BITS'(SUM_BITS - 1);

    logic                     busy_reg;
    logic                     done_reg;
    logic [DIV_STEP_BITS-1:0] step_reg;
    logic [CNT_BITS-1:0]      divisor_reg;
    logic [CNT_BITS-1:0]      rem_reg;
    logic [SUM_BITS-1:0]      quot_reg;
    logic [CNT_BITS:0]        shifted;
    logic [CNT_BITS+1:0]      diff;

    // one quotient bit per cycle
    assign shifted = {rem_reg, quot_reg[SUM_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor_reg};

    assign quotient = quot_reg;
    assign done     = done_reg;

    // iteration control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quot_reg    <= dividend;
        end else if (busy_reg) begin
            if (!diff[CNT_BITS+1]) begin
                rem_reg  <= diff[CNT_BITS-1:0];
                quot_reg <= {quot_reg[SUM_BITS-2:0], 1'b1};
            end else begin
                rem_reg  <= shifted[CNT_BITS-1:0];
                quot_reg <= {quot_reg[SUM_BITS-2:0], 1'b0};
            end
        end
    end

endmodule

// File: rtl/cte_datapath.sv
// episode state, step logic and result register
module cte_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  cte_pkg::cte_cmd_t                 cmd,
    output cte_pkg::cte_sts_t                 sts,
    input  cte_pkg::cte_cfg_t                 cfg,
    input  logic                              s_op,
    input  logic [cte_pkg::CLOCK_BITS-1:0]    s_trial_clock,
    input  logic [cte_pkg::TICK_BITS-1:0]     s_monitor_ticks,
    input  logic                              s_sample_valid,
    input  logic [cte_pkg::TEMP_BITS-1:0]     s_temp_c,
    input  logic [cte_pkg::UTIL_BITS-1:0]     s_util_pct,
    input  logic [cte_pkg::ECC_BITS-1:0]      s_ecc_count,
    output logic [1:0]                        m_propose_status,
    output logic                              m_clock_write,
    output logic [cte_pkg::CLOCK_BITS-1:0]    m_clock_value,
    output logic [2:0]                        m_phase,
    output logic [2:0]                        m_outcome,
    output logic [cte_pkg::UTIL_BITS-1:0]     m_mean_util,
    output logic [cte_pkg::EPISODE_BITS-1:0]  m_episode_number
);
    import cte_pkg::*;

    // captured item
    logic                  op_reg;
    logic [CLOCK_BITS-1:0] trial_in_reg;
    logic [TICK_BITS-1:0]  ticks_in_reg;
    logic                  sample_valid_reg;
    logic [TEMP_BITS-1:0]  temp_reg;
    logic [UTIL_BITS-1:0]  util_reg;
    logic                  ecc_err_reg;

    // episode state
    phase_t                  phase_reg, phase_next;
    logic [EPISODE_BITS-1:0] episode_reg, episode_next;
    logic [CLOCK_BITS-1:0]   trial_clock_reg, trial_clock_next;
    logic [TICK_BITS-1:0]    ticks_total_reg, ticks_total_next;
    logic [CNT_BITS-1:0]     ticks_done_reg, ticks_done_next;
    logic [SUM_BITS-1:0]     util_sum_reg, util_sum_next;
    logic [CNT_BITS-1:0]     sample_count_reg, sample_count_next;

    // step results
    status_t               status;
    logic                  clock_write;
    logic [CLOCK_BITS-1:0] clock_value;
    outcome_t              outcome;
    logic [UTIL_BITS-1:0]  avg;
    logic                  active;
    logic                  abort_now;
    logic [SUM_BITS-1:0]   quotient;
    logic                  div_done;

    // result register
    status_t                 status_reg;
    logic                    clock_write_reg;
    logic [CLOCK_BITS-1:0]   clock_value_reg;
    phase_t                  phase_out_reg;
    outcome_t                outcome_reg;
    logic [UTIL_BITS-1:0]    avg_reg;
    logic [EPISODE_BITS-1:0] episode_out_reg;

    cte_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (util_sum_reg),
        .divisor  (sample_count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    assign sts = '{decide_step: !op_reg && (phase_reg == PH_DECIDE), div_done: div_done};

    // capture the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg           <= s_op;
            trial_in_reg     <= s_trial_clock;
            ticks_in_reg     <= s_monitor_ticks;
            sample_valid_reg <= s_sample_valid;
            temp_reg         <= s_temp_c;
            util_reg         <= s_util_pct;
            ecc_err_reg      <= (s_ecc_count != '0);
        end
    end

    // one episode step
    always_comb begin
        phase_next        = phase_reg;
        episode_next      = episode_reg;
        trial_clock_next  = trial_clock_reg;
        ticks_total_next  = ticks_total_reg;
        ticks_done_next   = ticks_done_reg;
        util_sum_next     = util_sum_reg;
        sample_count_next = sample_count_reg;
        status            = PS_NONE;
        clock_write       = 1'b0;
        clock_value       = '0;
        outcome           = OC_NONE;
        avg               = '0;
        abort_now         = 1'b0;
        active            = phase_reg inside {[PH_PROPOSE:PH_ROLLBACK]};

        if (op_reg) begin
            if (active) begin
                status = PS_BUSY;
            end else begin
                status            = PS_ACCEPTED;
                episode_next      = episode_reg + 1'b1;
                phase_next        = PH_PROPOSE;
                trial_clock_next  = trial_in_reg;
                ticks_total_next  = ticks_in_reg;
                ticks_done_next   = '0;
                util_sum_next     = '0;
                sample_count_next = '0;
            end
        end else if (active) begin
            case (phase_reg)
                PH_PROPOSE: begin
                    phase_next = PH_VALIDATE;
                end
                PH_VALIDATE: begin
                    phase_next = PH_APPLY;
                end
                PH_APPLY: begin
                    clock_write = 1'b1;
                    clock_value = trial_clock_reg;
                    phase_next  = PH_MONITOR;
                end
                PH_MONITOR: begin
                    // accumulate the sample, abort on a guardrail hit
                    if (sample_valid_reg) begin
                        util_sum_next     = util_sum_reg + SUM_BITS'(util_reg);
                        sample_count_next = sample_count_reg + 1'b1;
                        abort_now = (temp_reg > cfg.temp_limit) || ecc_err_reg;
                    end
                    if (abort_now) begin
                        phase_next = PH_ROLLBACK;
                        outcome    = OC_GUARDRAIL;
                    end else begin
                        ticks_done_next = ticks_done_reg + 1'b1;
                        if (ticks_done_next >= {1'b0, ticks_total_reg}) begin
                            phase_next = PH_DECIDE;
                        end
                    end
                end
                PH_DECIDE: begin
                    // average comes from the divider, zero with no samples
                    if (sample_count_reg != '0) begin
                        avg = quotient[UTIL_BITS-1:0];
                    end
                    if (avg > cfg.util_threshold) begin
                        phase_next = PH_IDLE;
                        outcome    = OC_PROMOTED;
                    end else begin
                        phase_next = PH_ROLLBACK;
                        outcome    = OC_REJECTED;
                    end
                end
                default: begin
                    clock_write = 1'b1;
                    clock_value = cfg.baseline_clock;
                    phase_next  = PH_IDLE;
                    outcome     = OC_ROLLBACK_DONE;
                end
            endcase
        end else begin
            phase_next = PH_IDLE;
        end
    end

    // episode state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            episode_reg      <= '0;
            trial_clock_reg  <= '0;
            ticks_total_reg  <= '0;
            ticks_done_reg   <= '0;
            util_sum_reg     <= '0;
            sample_count_reg <= '0;
        end else if (cmd.commit) begin
            phase_reg        <= phase_next;
            episode_reg      <= episode_next;
            trial_clock_reg  <= trial_clock_next;
            ticks_total_reg  <= ticks_total_next;
            ticks_done_reg   <= ticks_done_next;
            util_sum_reg     <= util_sum_next;
            sample_count_reg <= sample_count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            status_reg      <= status;
            clock_write_reg <= clock_write;
            clock_value_reg <= clock_value;
            phase_out_reg   <= phase_next;
            outcome_reg     <= outcome;
            avg_reg         <= avg;
            episode_out_reg <= episode_next;
        end
    end

    assign m_propose_status = status_reg;
    assign m_clock_write    = clock_write_reg;
    assign m_clock_value    = clock_value_reg;
    assign m_phase          = phase_out_reg;
    assign m_outcome        = outcome_reg;
    assign m_mean_util      = avg_reg;
    assign m_episode_number = episode_out_reg;

endmodule

// File: rtl/cte_ctrl.sv
// handshake and sequencing controller
module cte_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output cte_pkg::cte_cmd_t  cmd,
    input  cte_pkg::cte_sts_t  sts
);
    import cte_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign s_ready  = (state_reg == CS_IDLE);
    assign m_valid  = m_valid_reg;
    assign out_free = !m_valid_reg || m_ready;

    // sequencing
    always_comb begin
        state_next    = state_reg;
        cmd.capture   = 1'b0;
        cmd.div_start = 1'b0;
        cmd.commit    = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = CS_STEP;
                end
            end
            CS_STEP: begin
                if (sts.decide_step) begin
                    cmd.div_start = 1'b1;
                    state_next    = CS_DIV;
                end else begin
                    state_next = CS_WRITE;
                end
            end
            CS_DIV: begin
                if (sts.div_done) begin
                    state_next = CS_WRITE;
                end
            end
            CS_WRITE: begin
                if (out_free) begin
                    cmd.commit = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // result valid
    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: rtl/clock_trial_episode_controller.sv
// top level of the clock trial episode controller
//
// Runs trial episodes of a proposed clock limit: propose, validate, apply,
// monitor, decide and rollback, one step per tick transfer, with one result
// transfer per input transfer. Items are taken one at a time. A tick or
// propose passes the capture, step and write states; a decide tick also
// waits in the divider state, where the bit-serial divider forms the
// average utilization one quotient bit per cycle (24 bits). A new input
// transfer is taken while the previous result waits in the output register.
// Registers on the APB port: temp_limit at 0x0, util_threshold at 0x4,
// baseline_clock at 0x8; write them only while the block is idle.
`include "clock_trial_episode_controller_assert.svh"

module clock_trial_episode_controller (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    input  logic [cte_pkg::CLOCK_BITS-1:0]     s_trial_clock,
    input  logic [cte_pkg::TICK_BITS-1:0]      s_monitor_ticks,
    input  logic                               s_sample_valid,
    input  logic [cte_pkg::TEMP_BITS-1:0]      s_temp_c,
    input  logic [cte_pkg::UTIL_BITS-1:0]      s_util_pct,
    input  logic [cte_pkg::ECC_BITS-1:0]       s_ecc_count,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_propose_status,
    output logic                               m_clock_write,
    output logic [cte_pkg::CLOCK_BITS-1:0]     m_clock_value,
    output logic [2:0]                         m_phase,
    output logic [2:0]                         m_outcome,
    output logic [cte_pkg::UTIL_BITS-1:0]      m_mean_util,
    output logic [cte_pkg::EPISODE_BITS-1:0]   m_episode_number,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cte_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cte_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cte_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);
    import cte_pkg::*;

    cte_cfg_t cfg;
    cte_cmd_t cmd;
    cte_sts_t sts;

    // result checks
    logic propose_taken;
    logic clock_phase_ok;
    logic mean_outcome_ok;

    cte_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    cte_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .cfg              (cfg),
        .s_op             (s_op),
        .s_trial_clock    (s_trial_clock),
        .s_monitor_ticks  (s_monitor_ticks),
        .s_sample_valid   (s_sample_valid),
        .s_temp_c         (s_temp_c),
        .s_util_pct       (s_util_pct),
        .s_ecc_count      (s_ecc_count),
        .m_propose_status (m_propose_status),
        .m_clock_write    (m_clock_write),
        .m_clock_value    (m_clock_value),
        .m_phase          (m_phase),
        .m_outcome        (m_outcome),
        .m_mean_util      (m_mean_util),
        .m_episode_number (m_episode_number)
    );

    assign propose_taken   = m_valid && (m_propose_status == PS_ACCEPTED);
    assign clock_phase_ok  = (m_phase == PH_MONITOR) || (m_phase == PH_IDLE);
    assign mean_outcome_ok = (m_outcome == OC_PROMOTED) || (m_outcome == OC_REJECTED);

    // one item in flight at a time
    `CTE_ASSERT_NXT(a_one_in_flight, s_valid && s_ready, !s_ready, "transfer taken while busy")

    // a clock is driven only by the apply or rollback steps
    `CTE_ASSERT_IMP(a_clock_step, m_valid && m_clock_write, clock_phase_ok, "stray clock write")

    // a nonzero average only comes with a decide outcome
    `CTE_ASSERT_IMP(a_avg_decide, m_valid && |m_mean_util, mean_outcome_ok, "stray average")

    // an accepted propose always lands in the propose phase
    `CTE_ASSERT_IMP(a_propose_phase, propose_taken, m_phase == PH_PROPOSE, "bad propose phase")

endmodule
